[src/kpg_pkg.sv]
// Shared types, codes and constants of the combined KISS random generator.
package kpg_pkg;

    localparam int RING_WORDS_DEF = 256;

    // Request codes
    localparam logic [2:0] OP_NEXT16  = 3'd0;
    localparam logic [2:0] OP_NEXT32  = 3'd1;
    localparam logic [2:0] OP_NEXT64  = 3'd2;
    localparam logic [2:0] OP_BOUNDED = 3'd3;
    localparam logic [2:0] OP_RESEED  = 3'd4;

    // Generator constants
    localparam logic [63:0] LCG_MUL   = 64'd1490024343005336237;
    localparam logic [63:0] LCG_ADD   = 64'd123456789;
    localparam logic [31:0] MWC1_MUL  = 32'd4294584393;
    localparam logic [31:0] MWC2_MUL  = 32'd4246477509;
    localparam logic [63:0] LCG_INIT  = 64'd123456789123;
    localparam logic [63:0] XS_INIT   = 64'd987654321987;
    localparam logic [31:0] MWC1_V0   = 32'd43219876;
    localparam logic [31:0] MWC1_C0   = 32'd6543217;
    localparam logic [31:0] MWC2_V0   = 32'd21987643;
    localparam logic [31:0] MWC2_C0   = 32'd1732654;
    localparam logic [31:0] SEED_LCG_MASK = 32'h5A5A5A5A;
    localparam logic [31:0] SEED_XS_MASK  = 32'hA5A5A5A5;

    // Request sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REFILL,
        ST_RD_LO,
        ST_RD_HI,
        ST_CAT,
        ST_FINISH
    } t_state;

    // Generator step sequencer states
    typedef enum logic [2:0] {
        G_IDLE,
        G_S0,
        G_S1,
        G_S2,
        G_S3,
        G_S4,
        G_S5,
        G_S6
    } t_gstep;

    typedef struct packed {
        logic        start;
        logic        reseed;
        logic [31:0] seed;
    } t_gen_ctrl;

    typedef struct packed {
        logic        busy;
        logic        word_valid;
        logic [63:0] word;
    } t_gen_stat;

endpackage

[src/kpg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kpg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/kpg_mul.sv]
// Shared 32 x 32 multiplier with a registered product.
module kpg_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[src/kpg_gen.sv]
// Generator state and word step: LCG, xorshift and two MWC on one multiplier.
module kpg_gen (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kpg_pkg::t_gen_ctrl  i_ctrl,
    output kpg_pkg::t_gen_stat  o_stat
);

    kpg_pkg::t_gstep r_step;
    kpg_pkg::t_gstep n_step;

    logic [63:0] r_lcg;
    logic [63:0] r_xs;
    logic [31:0] r_v1;
    logic [31:0] r_c1;
    logic [31:0] r_v2;
    logic [31:0] r_c2;
    logic [63:0] r_acc_lo;
    logic [31:0] r_cross;
    logic [63:0] r_part;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [63:0] w_xs1;
    logic [63:0] w_xs2;
    logic [63:0] w_xs3;
    logic [63:0] w_mwc;

    kpg_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    always_comb begin
        unique case (r_step)
            kpg_pkg::G_IDLE: n_step = i_ctrl.start ? kpg_pkg::G_S0 : kpg_pkg::G_IDLE;
            kpg_pkg::G_S0:   n_step = kpg_pkg::G_S1;
            kpg_pkg::G_S1:   n_step = kpg_pkg::G_S2;
            kpg_pkg::G_S2:   n_step = kpg_pkg::G_S3;
            kpg_pkg::G_S3:   n_step = kpg_pkg::G_S4;
            kpg_pkg::G_S4:   n_step = kpg_pkg::G_S5;
            kpg_pkg::G_S5:   n_step = kpg_pkg::G_S6;
            kpg_pkg::G_S6:   n_step = kpg_pkg::G_IDLE;
            default:         n_step = kpg_pkg::G_IDLE;
        endcase
    end

    // Operand select: low 64 bits of the LCG product take three partial products
    always_comb begin
        w_mul_a = kpg_pkg::LCG_MUL[31:0];
        w_mul_b = r_lcg[31:0];
        unique case (r_step)
            kpg_pkg::G_S1: begin
                w_mul_a = kpg_pkg::LCG_MUL[31:0];
                w_mul_b = r_lcg[63:32];
            end
            kpg_pkg::G_S2: begin
                w_mul_a = kpg_pkg::LCG_MUL[63:32];
                w_mul_b = r_lcg[31:0];
            end
            kpg_pkg::G_S3: begin
                w_mul_a = kpg_pkg::MWC1_MUL;
                w_mul_b = r_v1;
            end
            kpg_pkg::G_S4: begin
                w_mul_a = kpg_pkg::MWC2_MUL;
                w_mul_b = r_v2;
            end
            default: begin
                w_mul_a = kpg_pkg::LCG_MUL[31:0];
                w_mul_b = r_lcg[31:0];
            end
        endcase
    end

    assign w_xs1 = r_xs ^ (r_xs << 21);
    assign w_xs2 = w_xs1 ^ (w_xs1 >> 17);
    assign w_xs3 = w_xs2 ^ (w_xs2 << 30);

    // Product of the step before plus the carry of the MWC it belongs to
    assign w_mwc = w_prod + {32'd0, (r_step == kpg_pkg::G_S4) ? r_c1 : r_c2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= kpg_pkg::G_IDLE;
            r_lcg  <= kpg_pkg::LCG_INIT;
            r_xs   <= kpg_pkg::XS_INIT;
            r_v1   <= kpg_pkg::MWC1_V0;
            r_c1   <= kpg_pkg::MWC1_C0;
            r_v2   <= kpg_pkg::MWC2_V0;
            r_c2   <= kpg_pkg::MWC2_C0;
        end else begin
            r_step <= n_step;
            if (i_ctrl.reseed) begin
                r_lcg <= kpg_pkg::LCG_INIT ^ {32'd0, i_ctrl.seed & kpg_pkg::SEED_LCG_MASK};
                r_xs  <= kpg_pkg::XS_INIT ^ {32'd0, i_ctrl.seed & kpg_pkg::SEED_XS_MASK};
                r_v1  <= kpg_pkg::MWC1_V0;
                r_c1  <= kpg_pkg::MWC1_C0;
                r_v2  <= kpg_pkg::MWC2_V0;
                r_c2  <= kpg_pkg::MWC2_C0;
            end else begin
                unique case (r_step)
                    kpg_pkg::G_S0: r_xs <= w_xs3;
                    kpg_pkg::G_S4: begin
                        r_v1  <= w_mwc[31:0];
                        r_c1  <= w_mwc[63:32];
                        r_lcg <= r_acc_lo + {r_cross, 32'd0} + kpg_pkg::LCG_ADD;
                    end
                    kpg_pkg::G_S5: begin
                        r_v2 <= w_mwc[31:0];
                        r_c2 <= w_mwc[63:32];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_step)
            kpg_pkg::G_S1: r_acc_lo <= w_prod;
            kpg_pkg::G_S2: r_cross  <= w_prod[31:0];
            kpg_pkg::G_S3: r_cross  <= r_cross + w_prod[31:0];
            kpg_pkg::G_S5: r_part   <= r_lcg + r_xs;
            default: ;
        endcase
    end

    // mwc_one_value + (mwc_two_value << 32) is the plain concatenation
    assign o_stat.busy       = (r_step != kpg_pkg::G_IDLE);
    assign o_stat.word_valid = (r_step == kpg_pkg::G_S6);
    assign o_stat.word       = r_part + {r_v2, r_v1};

endmodule

[src/combined_kiss_prng_buffered.sv]
// Top level of the combined KISS random generator with halfword buffer.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_operation[2:0], i_limit[15:0]
//  out     | from block| o_out_valid / i_out_stall| o_value[63:0]
//  cfg     | to block  | i_cfg_valid / o_cfg_ready| i_cfg_seed_value[31:0]
//
// A request served from the buffer passes, after the idle state that takes it in,
// through pointer check, two buffer reads, assembly and output load. When too
// few halfwords remain, a refill runs first: one word at a time on the shared
// 32 x 32 multiplier, then a second pointer check. Each rejected bounded draw
// returns to the pointer check for a new draw, plus any refill it triggers. A
// reseed, a zero bound or an unused code goes from the idle state straight to
// the output load.
// Reset (synchronous, active low) loads the generator defaults and empties the
// buffer; buffer contents are not cleared, a refill always writes them first.
// A finished result waits in the output register while the next request is
// taken; a result that finds the output still stalled holds in its final state.
module combined_kiss_prng_buffered #(
    parameter int RING_WORDS = kpg_pkg::RING_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_limit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_seed_value
);

    localparam int HALFWORDS = 4 * RING_WORDS;
    localparam int PW = $clog2(HALFWORDS + 1);
    localparam int AW = (RING_WORDS > 1) ? $clog2(RING_WORDS) : 1;

    kpg_pkg::t_state r_state;
    kpg_pkg::t_state n_state;

    logic [31:0]   r_seed;
    logic [2:0]    r_op,  n_op;
    logic [15:0]   r_limit, n_limit;
    logic [15:0]   r_mask, n_mask;
    logic [2:0]    r_n, n_n;           // halfwords per draw: 1, 2 or 4
    logic [PW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_widx, n_widx;
    logic [63:0]   r_lo, n_lo;
    logic [63:0]   r_res, n_res;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_value, n_out_value;

    logic               w_accept;
    logic               w_out_take;
    logic               w_out_free;
    logic [15:0]        w_smear;
    logic [PW-1:0]      w_hi_ptr;
    logic [PW-1:0]      w_ptr_sh;
    logic [PW-1:0]      w_hi_sh;
    logic [127:0]       w_pair;
    logic [63:0]        w_draw;
    logic [63:0]        w_nmask;
    logic [15:0]        w_bounded;
    logic               w_reject;
    logic               w_last_word;

    logic               w_ram_we;
    logic [AW-1:0]      w_ram_raddr;
    logic [63:0]        w_ram_rdata;

    kpg_pkg::t_gen_ctrl w_gen_ctrl;
    kpg_pkg::t_gen_stat w_gen_stat;

    kpg_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_gen_ctrl),
        .o_stat  (w_gen_stat)
    );

    kpg_ram #(
        .WIDTH (64),
        .DEPTH (RING_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_widx),
        .i_wdata (w_gen_stat.word),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    assign o_in_stall  = (r_state != kpg_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Smear limit-1 into a mask covering its top set bit
    always_comb begin
        w_smear = i_limit - 16'd1;
        w_smear = w_smear | (w_smear >> 1);
        w_smear = w_smear | (w_smear >> 2);
        w_smear = w_smear | (w_smear >> 4);
        w_smear = w_smear | (w_smear >> 8);
    end

    // Word addresses of the lowest and highest halfword of the draw
    assign w_hi_ptr    = r_ptr + PW'(r_n) - PW'(1);
    assign w_ptr_sh    = r_ptr >> 2;
    assign w_hi_sh     = w_hi_ptr >> 2;
    assign w_last_word = (r_widx == AW'(RING_WORDS - 1));

    // Assemble the draw from the low word and the word now on the read port
    assign w_pair = {w_ram_rdata, r_lo} >> {r_ptr[1:0], 4'd0};

    always_comb begin
        priority if (r_n == 3'd1) begin
            w_nmask = 64'h0000_0000_0000_FFFF;
        end else if (r_n == 3'd2) begin
            w_nmask = 64'h0000_0000_FFFF_FFFF;
        end else begin
            w_nmask = '1;
        end
    end

    assign w_draw    = w_pair[63:0] & w_nmask;
    assign w_bounded = w_draw[15:0] & r_mask;
    assign w_reject  = (r_op == kpg_pkg::OP_BOUNDED) && (w_bounded >= r_limit);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kpg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    priority if (i_operation == kpg_pkg::OP_NEXT16
                                 || i_operation == kpg_pkg::OP_NEXT32
                                 || i_operation == kpg_pkg::OP_NEXT64) begin
                        n_state = kpg_pkg::ST_CHECK;
                    end else if (i_operation == kpg_pkg::OP_BOUNDED && i_limit != 16'd0) begin
                        n_state = kpg_pkg::ST_CHECK;
                    end else begin
                        n_state = kpg_pkg::ST_FINISH;
                    end
                end
            end
            kpg_pkg::ST_CHECK: begin
                n_state = (r_ptr < PW'(r_n)) ? kpg_pkg::ST_REFILL : kpg_pkg::ST_RD_LO;
            end
            kpg_pkg::ST_REFILL: begin
                if (w_gen_stat.word_valid && w_last_word) begin
                    n_state = kpg_pkg::ST_CHECK;
                end
            end
            kpg_pkg::ST_RD_LO: n_state = kpg_pkg::ST_RD_HI;
            kpg_pkg::ST_RD_HI: n_state = kpg_pkg::ST_CAT;
            kpg_pkg::ST_CAT: begin
                n_state = w_reject ? kpg_pkg::ST_CHECK : kpg_pkg::ST_FINISH;
            end
            kpg_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = kpg_pkg::ST_IDLE;
                end
            end
            default: n_state = kpg_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath next values
    always_comb begin
        n_op        = r_op;
        n_limit     = r_limit;
        n_mask      = r_mask;
        n_n         = r_n;
        n_ptr       = r_ptr;
        n_widx      = r_widx;
        n_lo        = r_lo;
        n_res       = r_res;
        n_out_valid = r_out_valid && !w_out_take;
        n_out_value = r_out_value;
        w_ram_we    = 1'b0;
        w_ram_raddr = w_ptr_sh[AW-1:0];
        w_gen_ctrl.start  = 1'b0;
        w_gen_ctrl.reseed = 1'b0;
        w_gen_ctrl.seed   = r_seed;

        unique case (r_state)
            kpg_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op    = i_operation;
                    n_limit = i_limit;
                    n_mask  = w_smear;
                    n_res   = 64'd0;
                    priority if (i_operation == kpg_pkg::OP_NEXT32) begin
                        n_n = 3'd2;
                    end else if (i_operation == kpg_pkg::OP_NEXT64) begin
                        n_n = 3'd4;
                    end else begin
                        n_n = 3'd1;
                    end
                    if (i_operation == kpg_pkg::OP_RESEED) begin
                        w_gen_ctrl.reseed = 1'b1;
                        n_ptr = '0;
                    end
                end
            end
            kpg_pkg::ST_CHECK: begin
                if (r_ptr < PW'(r_n)) begin
                    n_widx = '0;
                end else begin
                    n_ptr = r_ptr - PW'(r_n);
                end
            end
            kpg_pkg::ST_REFILL: begin
                w_gen_ctrl.start = !w_gen_stat.busy;
                if (w_gen_stat.word_valid) begin
                    w_ram_we = 1'b1;
                    if (w_last_word) begin
                        n_ptr = PW'(HALFWORDS);
                    end else begin
                        n_widx = r_widx + AW'(1);
                    end
                end
            end
            kpg_pkg::ST_RD_LO: begin
                w_ram_raddr = w_ptr_sh[AW-1:0];
            end
            kpg_pkg::ST_RD_HI: begin
                w_ram_raddr = w_hi_sh[AW-1:0];
                n_lo        = w_ram_rdata;
            end
            kpg_pkg::ST_CAT: begin
                if (r_op == kpg_pkg::OP_BOUNDED) begin
                    n_res = {48'd0, w_bounded};
                end else begin
                    n_res = w_draw;
                end
            end
            kpg_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kpg_pkg::ST_IDLE;
            r_seed      <= 32'd0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_cfg_seed_value;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_limit     <= n_limit;
        r_mask      <= n_mask;
        r_n         <= n_n;
        r_widx      <= n_widx;
        r_lo        <= n_lo;
        r_res       <= n_res;
        r_out_value <= n_out_value;
    end

endmodule

[src/kpg_checker.sv]
// Port-level checker for the combined KISS random generator, bound to the top level.
module kpg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_value
);

    logic [1:0] r_pend;

    // Count transfers taken in but not yet handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
        end else begin
            r_pend <= r_pend + 2'(i_in_valid && !o_in_stall)
                             - 2'(o_out_valid && !i_out_stall);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one still in work");

    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result shown with no request outstanding");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more than two requests outstanding");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind combined_kiss_prng_buffered kpg_checker u_kpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value)
);

[test/tb_combined_kiss_prng_buffered.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the combined KISS generator with halfword buffer.
module tb_combined_kiss_prng_buffered;

    localparam int WORDS       = kpg_pkg::RING_WORDS_DEF;
    localparam int HALFWORDS   = 4 * WORDS;
    localparam int CYCLE_LIMIT = 1_000_000;

    // Request codes the block does not define; they must answer zero and leave state alone
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Generator constants, kept apart from the package so the prediction stands on its own
    localparam logic [63:0] GEN_LCG_MULT   = 64'd1490024343005336237;
    localparam logic [63:0] GEN_LCG_ADD    = 64'd123456789;
    localparam logic [63:0] GEN_MWC_A_MULT = 64'd4294584393;
    localparam logic [63:0] GEN_MWC_B_MULT = 64'd4246477509;
    localparam logic [63:0] GEN_LCG_START  = 64'd123456789123;
    localparam logic [63:0] GEN_XS_START   = 64'd987654321987;
    localparam logic [31:0] GEN_MWC_A_VAL0 = 32'd43219876;
    localparam logic [31:0] GEN_MWC_A_CAR0 = 32'd6543217;
    localparam logic [31:0] GEN_MWC_B_VAL0 = 32'd21987643;
    localparam logic [31:0] GEN_MWC_B_CAR0 = 32'd1732654;
    localparam logic [31:0] GEN_SEED_LCG   = 32'h5A5A_5A5A;
    localparam logic [31:0] GEN_SEED_XS    = 32'hA5A5_A5A5;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  in_operation;
    logic [15:0] in_limit;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_seed;

    // Predicted generator state: a private copy of everything the block keeps
    logic [63:0] lcg_word;
    logic [63:0] xs_word;
    logic [31:0] mwc_a_val;
    logic [31:0] mwc_a_carry;
    logic [31:0] mwc_b_val;
    logic [31:0] mwc_b_carry;
    logic [63:0] ring_copy [WORDS];
    int unsigned halfwords_left;
    logic [31:0] seed_reg;

    // Values the block owes us, oldest first
    logic [63:0] expected_values [$];

    int error_count;
    int cycle_count;
    int stall_left;
    bit idle_on;

    combined_kiss_prng_buffered uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (in_operation),
        .i_limit          (in_limit),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_value          (value),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_seed_value (cfg_seed)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: the slowest legitimate run is far below this
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Restore the power-on generator values and mark the buffer empty
    function automatic void load_generator_defaults();
        lcg_word       = GEN_LCG_START;
        xs_word        = GEN_XS_START;
        mwc_a_val      = GEN_MWC_A_VAL0;
        mwc_a_carry    = GEN_MWC_A_CAR0;
        mwc_b_val      = GEN_MWC_B_VAL0;
        mwc_b_carry    = GEN_MWC_B_CAR0;
        halfwords_left = 0;
    endfunction

    // Step all four generators once per word and store their 64-bit sum
    function automatic void refill_ring();
        logic [63:0] prod;
        for (int i = 0; i < WORDS; i++) begin
            lcg_word = GEN_LCG_MULT * lcg_word + GEN_LCG_ADD;

            xs_word ^= xs_word << 21;
            xs_word ^= xs_word >> 17;
            xs_word ^= xs_word << 30;

            prod        = GEN_MWC_A_MULT * {32'd0, mwc_a_val} + {32'd0, mwc_a_carry};
            mwc_a_carry = prod[63:32];
            mwc_a_val   = prod[31:0];

            prod        = GEN_MWC_B_MULT * {32'd0, mwc_b_val} + {32'd0, mwc_b_carry};
            mwc_b_carry = prod[63:32];
            mwc_b_val   = prod[31:0];

            ring_copy[i] = lcg_word + xs_word + {32'd0, mwc_a_val} + {mwc_b_val, 32'd0};
        end
        halfwords_left = HALFWORDS;
    endfunction

    // Pull count halfwords off the top, lowest halfword least significant
    function automatic logic [63:0] take_halfwords(int unsigned count);
        logic [63:0] bits;
        int unsigned h;
        bits = '0;
        if (halfwords_left < count || halfwords_left > HALFWORDS)
            refill_ring();
        halfwords_left -= count;
        for (int k = 0; k < count; k++) begin
            h = halfwords_left + k;
            bits |= ((ring_copy[h >> 2] >> (16 * (h & 3))) & 64'hFFFF) << (16 * k);
        end
        return bits;
    endfunction

    function automatic logic [63:0] predict_value(logic [2:0] op, logic [15:0] lim);
        logic [63:0] result;
        logic [15:0] mask;
        logic [15:0] draw;
        result = '0;
        case (op)
            kpg_pkg::OP_NEXT16: result = take_halfwords(1);
            kpg_pkg::OP_NEXT32: result = take_halfwords(2);
            kpg_pkg::OP_NEXT64: result = take_halfwords(4);
            kpg_pkg::OP_BOUNDED: begin
                // A zero bound consumes nothing and answers zero
                if (lim != 16'd0) begin
                    mask = lim - 16'd1;
                    mask |= mask >> 1;
                    mask |= mask >> 2;
                    mask |= mask >> 4;
                    mask |= mask >> 8;
                    do
                        draw = mask & 16'(take_halfwords(1));
                    while (draw >= lim);
                    result = {48'd0, draw};
                end
            end
            kpg_pkg::OP_RESEED: begin
                load_generator_defaults();
                lcg_word ^= {32'd0, seed_reg & GEN_SEED_LCG};
                xs_word  ^= {32'd0, seed_reg & GEN_SEED_XS};
            end
            default: ;
        endcase
        return result;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Present one request after a random gap, hold it until the transfer, then predict.
    // Valid is left high so that a following request can go out back to back.
    task automatic send_request(input logic [2:0] op, input logic [15:0] lim);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        in_operation <= op;
        in_limit     <= lim;
        do @(posedge clk); while (in_stall);
        expected_values.push_back(predict_value(op, lim));
    endtask

    // Drop valid and wait for every outstanding result to be transferred
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
    endtask

    // Only write the seed with the block idle; it takes effect on the next reseed
    task automatic write_seed(input logic [31:0] seed);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_seed  <= seed;
        do @(posedge clk); while (!cfg_ready);
        seed_reg = seed;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side: stall each result for a random number of cycles while it waits
    always @(negedge clk) begin
        if (out_valid === 1'b1 && stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Compare every result transfer against the oldest prediction
    always @(posedge clk) begin : value_check
        logic [63:0] want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (expected_values.size() == 0) begin
                $error("value: unexpected result %h with nothing pending", value);
                error_count++;
            end else begin
                want = expected_values.pop_front();
                if (value !== want) begin
                    $error("value mismatch: expected %h, actual %h", want, value);
                    error_count++;
                end
            end
            stall_left = idle_on ? $urandom_range(0, 3) : 0;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every request code and the corner cases of the bounded draw
    task automatic test_directed();
        write_seed(32'd0);
        idle_on = 1'b0;
        // first read of all finds the buffer empty and forces a refill
        send_request(kpg_pkg::OP_NEXT16, 16'hFFFF);
        send_request(kpg_pkg::OP_NEXT32, 16'h0000);
        send_request(kpg_pkg::OP_NEXT64, 16'h5555);
        // bound of one always yields zero but still eats a halfword
        send_request(kpg_pkg::OP_BOUNDED, 16'd1);
        // bound of zero: no halfword taken
        send_request(kpg_pkg::OP_BOUNDED, 16'd0);
        send_request(kpg_pkg::OP_BOUNDED, 16'hFFFF);
        // a power of two never rejects; one above it rejects about half the time
        send_request(kpg_pkg::OP_BOUNDED, 16'h8000);
        send_request(kpg_pkg::OP_BOUNDED, 16'h8001);
        send_request(kpg_pkg::OP_BOUNDED, 16'd2);
        send_request(kpg_pkg::OP_BOUNDED, 16'd3);
        for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
            send_request(3'(op), 16'($urandom));
        idle_on = 1'b1;
        // reseed with seed zero must reproduce the power-on sequence; limit is ignored
        send_request(kpg_pkg::OP_RESEED, 16'hFFFF);
        send_request(kpg_pkg::OP_NEXT64, 16'd0);
        send_request(kpg_pkg::OP_NEXT16, 16'hAAAA);
        // pointer now sits off a word boundary, so this read straddles two words
        send_request(kpg_pkg::OP_NEXT64, 16'h1234);
        send_request(kpg_pkg::OP_NEXT32, 16'h8000);
    endtask

    // Walk the seed register through its extremes and check each reseed
    task automatic test_seed_settings();
        logic [31:0] seeds [5];
        seeds = '{32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'($urandom), 32'h0000_0000};
        foreach (seeds[s]) begin
            write_seed(seeds[s]);
            send_request(kpg_pkg::OP_RESEED, 16'($urandom));
            send_request(kpg_pkg::OP_NEXT64, 16'($urandom));
            send_request(kpg_pkg::OP_BOUNDED, 16'($urandom_range(1, 16'hFFFF)));
        end
    endtask

    // Drain the buffer right down, then ask for more than remains
    task automatic test_buffer_exhaust();
        send_request(kpg_pkg::OP_RESEED, 16'd0);
        send_request(kpg_pkg::OP_NEXT16, 16'($urandom));
        // 64-bit reads from an odd pointer: every one spans two words
        for (int n = 0; n < HALFWORDS / 4 - 1; n++) begin
            idle_on = (n % 64) >= 32;
            send_request(kpg_pkg::OP_NEXT64, 16'($urandom));
        end
        // three halfwords left: one 32-bit read fits, the next is one short
        send_request(kpg_pkg::OP_NEXT32, 16'($urandom));
        send_request(kpg_pkg::OP_NEXT32, 16'($urandom));
        send_request(kpg_pkg::OP_NEXT64, 16'($urandom));
        idle_on = 1'b1;
    endtask

    // Random mix of requests, with a seed change before every 275th request
    task automatic test_random_mix();
        logic [2:0]  op;
        logic [15:0] lim;
        int pick;
        for (int n = 0; n < 1100; n++) begin
            if (n % 100 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (n % 275 == 274)
                write_seed($urandom);
            pick = $urandom_range(0, 99);
            lim  = 16'($urandom);
            if (pick < 20) begin
                op = kpg_pkg::OP_NEXT16;
            end else if (pick < 40) begin
                op = kpg_pkg::OP_NEXT32;
            end else if (pick < 65) begin
                op = kpg_pkg::OP_NEXT64;
            end else if (pick < 93) begin
                op = kpg_pkg::OP_BOUNDED;
                // bias the bound towards the edges of the mask smearing
                case ($urandom_range(0, 4))
                    0:       lim = 16'd1 << $urandom_range(0, 15);
                    1:       lim = (16'd1 << $urandom_range(0, 15)) + 16'd1;
                    2:       lim = 16'($urandom_range(0, 16));
                    default: ;
                endcase
            end else if (pick < 95) begin
                op = kpg_pkg::OP_RESEED;
            end else begin
                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end
            send_request(op, lim);
        end
    endtask

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_operation = kpg_pkg::OP_NEXT16;
        in_limit     = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_seed     = '0;
        idle_on      = 1'b1;
        error_count  = 0;
        cycle_count  = 0;
        stall_left   = 0;

        load_generator_defaults();
        seed_reg = '0;
        foreach (ring_copy[i])
            ring_copy[i] = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_seed_settings();
        test_buffer_exhaust();
        test_random_mix();

        drain_results();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
src/kpg_pkg.sv
src/kpg_ram.sv
src/kpg_mul.sv
src/kpg_gen.sv
src/combined_kiss_prng_buffered.sv
src/kpg_checker.sv
test/tb_combined_kiss_prng_buffered.sv
